FILE: design/sotq_pkg.sv
`default_nettype none
package sotq_pkg;
  localparam int unsigned QueueDepthDefault = 8;
  localparam int unsigned OscWidth   = 26;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned DelayWidth = 24;
  localparam int unsigned TagWidth   = 8;
  localparam int unsigned CmpWidth   = 15;
  localparam logic [OscWidth-1:0] OscReset = 26'd24000000;
  localparam logic [23:0] UsecScale = 24'd10000000;
  localparam logic [CmpWidth-1:0] CmpSat = 15'h7fff;

  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_MATCH = 1'b1
  } kind_e;

  typedef struct packed {
    logic                  kind;
    logic [CountWidth-1:0] counter_value;
    logic [DelayWidth-1:0] delay_us;
    logic [TagWidth-1:0]   tag;
  } req_t;

  typedef struct packed {
    logic                expired_valid;
    logic [TagWidth-1:0] expired_tag;
    logic                rejected;
    logic [CmpWidth-1:0] compare_count;
    logic                counter_run;
    logic                last;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ELAPSED,
    ST_DIV_ELAPSED,
    ST_POP,
    ST_SUB,
    ST_FIND,
    ST_SHIFT,
    ST_MUL_CMP,
    ST_DIV_CMP,
    ST_FINAL
  } state_e;
endpackage
`default_nettype wire

FILE: design/sotq_front.sv
`default_nettype none
// Input FIFO of two requests; decouples the caller from the engine.
module sotq_front
  import sotq_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  output logic full_o,
  input  req_t req_i,
  output logic vld_o,
  input  wire  take_i,
  output req_t req_o
);
  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign vld_o  = (cnt_q != 2'd0);
  assign req_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (take_i && vld_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, take_i && vld_o};
    end
  end
endmodule
`default_nettype wire

FILE: design/sotq_out_fifo.sv
`default_nettype none
// Result FIFO; holds a whole event's results so the engine never waits mid-event.
module sotq_out_fifo
  import sotq_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault + 2
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  wr_i,
  input  rsp_t rsp_i,
  output logic room_o,
  output logic empty_o,
  input  wire  pop_i,
  output rsp_t rsp_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw = $clog2(Depth + 1);
  rsp_t          mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Cw-1:0] cnt_q;
  logic          do_pop;

  assign empty_o = (cnt_q == '0);
  assign room_o  = (cnt_q == '0);
  assign rsp_o   = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= rsp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (do_pop) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + Cw'(wr_i) - Cw'(do_pop);
    end
  end
endmodule
`default_nettype wire

FILE: design/sotq_engine.sv
`default_nettype none
// Back end: time conversion, pops, ageing, sorted insert, compare setup.
module sotq_engine
  import sotq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire [OscWidth-1:0]  osc_hz_i,
  input  wire                 vld_i,
  input  req_t                req_i,
  output logic                take_o,
  input  wire                 room_i,
  output logic                wr_o,
  output rsp_t                rsp_o
);
  localparam int unsigned Iw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned Nw = $clog2(QueueDepth + 1);
  localparam int unsigned Pw = 42;  // count * 10^7 fits in 40 bits
  localparam int unsigned Cw = 52;  // osc_hz * remaining fits in 52 bits
  // products at or above 0x8000 * 10^7 saturate the compare count
  localparam logic [Cw-1:0] CmpOverflow = 52'd327680000000;
  // ceil(2^49 / 78125): divides the product, already shifted down by 7,
  // by 78125; exact for any 32-bit operand
  localparam logic [32:0] CmpRecip = 33'd7205759404;

  state_e state_q, state_d;
  logic [OscWidth-1:0] rem_q [QueueDepth];
  logic [TagWidth-1:0] tag_q [QueueDepth];
  logic [Nw-1:0] cnt_q;
  logic [Nw-1:0] idx_q;
  req_t          req_q;
  logic [Pw-1:0] prod_q;   // dividend, shifted out as quotient bits come in
  logic [25:0]   rem_div_q;
  logic [5:0]    bit_q;
  logic [Pw-1:0] elapsed_q;
  logic          rej_q;
  logic [Cw-1:0] cmp_prod_q;
  logic [CmpWidth-1:0] cmp_q;
  logic [64:0]   cmp_quot;
  logic [OscWidth-1:0] freq;
  logic [Iw-1:0] idx;

  assign freq     = (osc_hz_i == '0) ? OscWidth'(1) : osc_hz_i;
  assign idx      = idx_q[Iw-1:0];
  assign cmp_quot = 65'(cmp_prod_q[38:7]) * 65'(CmpRecip);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:        if (vld_i) state_d = ST_MUL_ELAPSED;
      ST_MUL_ELAPSED: state_d = ST_DIV_ELAPSED;
      ST_DIV_ELAPSED: if (bit_q == 6'd0) state_d = ST_POP;
      ST_POP: begin
        if (cnt_q == '0 || Pw'(rem_q[0]) > elapsed_q) state_d = ST_SUB;
        else if (room_i) state_d = ST_POP;
      end
      ST_SUB: begin
        if (idx_q + 1'b1 >= cnt_q) begin
          state_d = (req_q.kind == KIND_ADD) ? ST_FIND : ST_MUL_CMP;
        end
      end
      ST_FIND: begin
        if (cnt_q == Nw'(QueueDepth)) state_d = ST_MUL_CMP;
        else if (idx_q == cnt_q || rem_q[idx] >= OscWidth'(req_q.delay_us))
          state_d = ST_SHIFT;
      end
      ST_SHIFT:   state_d = ST_MUL_CMP;
      ST_MUL_CMP: state_d = ST_DIV_CMP;
      ST_DIV_CMP: state_d = ST_FINAL;
      ST_FINAL:   if (room_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    take_o = (state_q == ST_IDLE) && vld_i;
    wr_o   = 1'b0;
    rsp_o  = '0;
    if (state_q == ST_POP && cnt_q != '0 && Pw'(rem_q[0]) <= elapsed_q && room_i) begin
      wr_o = 1'b1;
      rsp_o.expired_valid = 1'b1;
      rsp_o.expired_tag   = tag_q[0];
    end
    if (state_q == ST_FINAL && room_i) begin
      wr_o = 1'b1;
      rsp_o.last        = 1'b1;
      rsp_o.rejected    = rej_q;
      rsp_o.counter_run = (cnt_q != '0);
      if (cnt_q != '0) begin
        rsp_o.compare_count = cmp_q;
      end
    end
  end

  // Datapath registers and queue storage: the queue shifts by one slot for each pop and for an insert.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && vld_i) req_q <= req_i;
    unique case (state_q)
      ST_MUL_ELAPSED: begin
        prod_q    <= Pw'(req_q.counter_value) * Pw'(UsecScale);
        rem_div_q <= '0;
        bit_q     <= 6'(Pw);
      end
      ST_DIV_ELAPSED: begin
        // restoring divide, one quotient bit per cycle
        if (bit_q != 6'd0) begin
          if ({rem_div_q, prod_q[Pw-1]} >= {1'b0, freq}) begin
            rem_div_q <= 26'({rem_div_q, prod_q[Pw-1]} - {1'b0, freq});
            prod_q    <= {prod_q[Pw-2:0], 1'b1};
          end else begin
            rem_div_q <= {rem_div_q[24:0], prod_q[Pw-1]};
            prod_q    <= {prod_q[Pw-2:0], 1'b0};
          end
          bit_q <= bit_q - 1'b1;
        end else begin
          elapsed_q <= prod_q;
        end
      end
      ST_POP: begin
        if (cnt_q != '0 && Pw'(rem_q[0]) <= elapsed_q && room_i) begin
          for (int i = 0; i < QueueDepth - 1; i++) begin
            rem_q[i] <= rem_q[i+1];
            tag_q[i] <= tag_q[i+1];
          end
        end
      end
      ST_SUB: if (cnt_q != '0) rem_q[idx] <= rem_q[idx] - elapsed_q[OscWidth-1:0];
      ST_SHIFT: begin
        for (int i = 1; i < QueueDepth; i++) begin
          if (Nw'(i) > idx_q && Nw'(i) <= cnt_q) begin
            rem_q[i] <= rem_q[i-1];
            tag_q[i] <= tag_q[i-1];
          end
        end
        rem_q[idx] <= OscWidth'(req_q.delay_us);
        tag_q[idx] <= req_q.tag;
      end
      ST_MUL_CMP: cmp_prod_q <= Cw'(osc_hz_i) * Cw'(rem_q[0]);
      // scale down by 10^7 as a shift by 7 and a reciprocal multiply
      ST_DIV_CMP: cmp_q <= (cmp_prod_q >= CmpOverflow) ? CmpSat
                                                       : cmp_quot[CmpWidth+48:49];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      rej_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          rej_q <= 1'b0;
        end
        ST_POP: begin
          if (cnt_q != '0 && Pw'(rem_q[0]) <= elapsed_q && room_i) cnt_q <= cnt_q - 1'b1;
          idx_q <= '0;
        end
        ST_SUB: idx_q <= (idx_q + 1'b1 >= cnt_q) ? '0 : idx_q + 1'b1;
        ST_FIND: begin
          if (cnt_q == Nw'(QueueDepth)) rej_q <= 1'b1;
          else if (!(idx_q == cnt_q || rem_q[idx] >= OscWidth'(req_q.delay_us)))
            idx_q <= idx_q + 1'b1;
        end
        ST_SHIFT: cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/sorted_oneshot_timer_queue_core.sv
`default_nettype none
// Sorted one-shot timer queue.
// Input queue: drive req_i and push_i; a request is taken when push_i is
// high and full_o low. Two requests may wait ahead of the engine.
// Result queue: while empty_o is low the oldest result sits on rsp_o;
// pop_i takes it. Each request gives one result per expired entry and a
// final result (last set) carrying the compare count and run/stop.
// Write osc_hz with cfg_we_i / cfg_wdata_i only while idle.
// From the engine taking a request to its final result, the work is a
// 42-step bit-serial division of the elapsed time by osc_hz and the
// one-slot-per-cycle walk over the queue for ageing and insertion; the
// compare count is a product, then a reciprocal multiply by the fixed
// scale.
// Throughput: one request per event time plus the drain of its results.
// The engine starts a request only when the result queue is drained, so
// a stalled receiver holds the engine; the input queue still fills.
// Reset clears the queue count and the input and result queue pointers
// and sets osc_hz to 24 MHz; no clearing pass is needed.
module sorted_oneshot_timer_queue_core
  import sotq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [OscWidth-1:0] cfg_wdata_i,
  input  wire                push_i,
  output logic               full_o,
  input  req_t               req_i,
  output logic               empty_o,
  input  wire                pop_i,
  output rsp_t               rsp_o
);
  logic [OscWidth-1:0] osc_q;
  logic vld, take, room, wr, idle_ok;
  req_t req;
  rsp_t rsp;

  // hold the frequency register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) osc_q <= OscReset;
    else if (cfg_we_i) osc_q <= cfg_wdata_i;
  end

  sotq_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .req_i,
    .vld_o(vld), .take_i(take), .req_o(req)
  );

  // start a request only with the result queue drained
  assign idle_ok = vld && room;

  sotq_engine #(.QueueDepth(QueueDepth)) u_engine (
    .clk_i, .rst_ni, .osc_hz_i(osc_q), .vld_i(idle_ok), .req_i(req),
    .take_o(take), .room_i(1'b1), .wr_o(wr), .rsp_o(rsp)
  );

  sotq_out_fifo #(.Depth(QueueDepth + 2)) u_out (
    .clk_i, .rst_ni, .wr_i(wr), .rsp_i(rsp), .room_o(room),
    .empty_o, .pop_i, .rsp_o
  );
endmodule
`default_nettype wire

FILE: design/sotq_checker.sv
`default_nettype none
module sotq_checker
  import sotq_pkg::*;
(
  input wire  clk_i,
  input wire  rst_ni,
  input wire  empty_o,
  input wire  pop_i,
  input rsp_t rsp_o
);
  a_last_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && rsp_o.last) |-> !rsp_o.expired_valid) else $error("final item flagged expired");
  a_exp_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && rsp_o.expired_valid) |-> (!rsp_o.last && !rsp_o.counter_run))
    else $error("expiry item carries compare setup");
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !rsp_o.counter_run) |-> rsp_o.compare_count == '0)
    else $error("stopped counter with compare count");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> !empty_o) else $error("result vanished");
endmodule

bind sorted_oneshot_timer_queue_core sotq_checker u_checker (
  .clk_i, .rst_ni, .empty_o, .pop_i, .rsp_o
);
`default_nettype wire
